// File: rtl/pcbp_pkg.sv
// ----------------------------------------------------------------------------
// pcbp_pkg - shared types and constants of the prefix code bit packer
// Field widths, command codes and the op descriptor passed front to back.
// ----------------------------------------------------------------------------
package pcbp_pkg;

    localparam int CMD_W     = 2;
    localparam int SYM_W     = 8;
    localparam int CODE_IN_W = 64;
    localparam int LEN_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 3;

    // op queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

    typedef struct packed {
        logic             is_flush;
        logic [LEN_W-1:0] len;
    } t_op_ctl;

endpackage

// File: rtl/pcbp_in_if.sv
// ----------------------------------------------------------------------------
// pcbp_in_if - input word channel
// valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
interface pcbp_in_if
    import pcbp_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [SYM_W-1:0]     symbol;
    logic [CODE_IN_W-1:0] code_bits;
    logic [LEN_W-1:0]     code_len;

    modport source (output valid, output command, output symbol,
                    output code_bits, output code_len, input ready);
    modport sink   (input valid, input command, input symbol,
                    input code_bits, input code_len, output ready);
endinterface

// File: rtl/pcbp_out_if.sv
// ----------------------------------------------------------------------------
// pcbp_out_if - output word channel
// valid/ready handshake carrying one packed byte and its last flag.
// ----------------------------------------------------------------------------
interface pcbp_out_if
    import pcbp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// File: rtl/prefix_code_bit_packer_core.sv
// ----------------------------------------------------------------------------
// prefix_code_bit_packer_core - prefix code bit packer, top level
// Loads a per-symbol code table, packs symbol codes into bytes msb first,
// and closes a stream with a partial byte and a leftover-count trailer.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake        word
//  i_in     in   valid & ready    command, symbol, code_bits, code_len
//  o_out    out  valid & ready    out_byte, last (set on the trailer word)
//
//  Throughput: one command word per cycle while the op queue has room.
//  Load words finish in the front. An encode emits each byte it completes,
//  then merges any bits left over into the pending byte; a flush emits the
//  partial byte, if there is one, and then the leftover-count trailer.
//  An input word passes the front stage register, the op queue, the packer
//  state and the output register on its way to the first output byte.
//  Reset (sync, active low) clears the length-valid bits, the op queue,
//  the pending bits and the output register; code memory is not cleared.
//  Output stall backs up the packer, then the queue, then i_in.ready.
//
module prefix_code_bit_packer_core
    import pcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = 64,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pcbp_in_if.sink      i_in,
    pcbp_out_if.source   o_out
);

    // codes travel left-aligned, at least one byte wide
    localparam int CODE_W = (MAX_CODE_LEN < BYTE_W) ? BYTE_W : MAX_CODE_LEN;

    logic              q_full;
    logic              q_push;
    t_op_ctl           push_ctl;
    logic [CODE_W-1:0] push_code;

    logic              q_vld;
    logic              q_pop;
    t_op_ctl           head_ctl;
    logic [CODE_W-1:0] head_code;

    // front: table load/lookup, forms one op per encode or flush
    pcbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_ctl    (push_ctl),
        .o_code   (push_code)
    );

    // short queue so lookup and packing stall independently
    pcbp_queue #(
        .CODE_W (CODE_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_ctl   (push_ctl),
        .i_code  (push_code),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_ctl   (head_ctl),
        .o_code  (head_code)
    );

    // back: bit packing, byte emission, flush trailer
    pcbp_back #(
        .CODE_W (CODE_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_vld (q_vld),
        .i_ctl   (head_ctl),
        .i_code  (head_code),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

// File: rtl/pcbp_front.sv
// ----------------------------------------------------------------------------
// pcbp_front - command intake and code table
// Writes the code table on loads, looks up codes on encodes and hands
// left-aligned ops to the queue.
// ----------------------------------------------------------------------------
module pcbp_front
    import pcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = 64,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pcbp_in_if.sink             i_in,
    input  logic                i_q_full,
    output logic                o_push,
    output t_op_ctl             o_ctl,
    output logic [((MAX_CODE_LEN < BYTE_W) ? BYTE_W : MAX_CODE_LEN)-1:0] o_code
);

    localparam int CODE_W = (MAX_CODE_LEN < BYTE_W) ? BYTE_W : MAX_CODE_LEN;
    localparam int SYM_IW = $clog2(SYMBOL_COUNT);

    logic [MAX_CODE_LEN-1:0] code_mem [SYMBOL_COUNT];
    logic [LEN_W-1:0]        len_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_loaded;

    logic                    r_st_vld;
    logic                    r_st_flush;
    logic                    r_st_hit;
    logic [MAX_CODE_LEN-1:0] r_rd_code;
    logic [LEN_W-1:0]        r_rd_len;

    logic                    accept;
    logic                    in_range;
    logic [SYM_IW-1:0]       sym_idx;
    logic [LEN_W-1:0]        len_c;
    logic [MAX_CODE_LEN-1:0] code_mask;
    logic [MAX_CODE_LEN-1:0] code_w;
    logic [LEN_W-1:0]        op_len;

    assign o_push     = r_st_vld && !i_q_full;
    assign i_in.ready = !r_st_vld || o_push;
    assign accept     = i_in.valid && i_in.ready;

    assign sym_idx  = i_in.symbol[SYM_IW-1:0];
    assign in_range = {1'b0, i_in.symbol} < (SYM_W+1)'(SYMBOL_COUNT);

    // clamp over-long lengths, drop code bits above the length
    assign len_c = (i_in.code_len > LEN_W'(MAX_CODE_LEN)) ?
                   LEN_W'(MAX_CODE_LEN) : i_in.code_len;
    assign code_mask = ~({MAX_CODE_LEN{1'b1}} << len_c);
    assign code_w    = i_in.code_bits[MAX_CODE_LEN-1:0] & code_mask;

    // table write on load
    always_ff @(posedge i_clk) begin
        if (accept && (i_in.command == CMD_LOAD) && in_range) begin
            code_mem[sym_idx] <= code_w;
            len_mem[sym_idx]  <= len_c;
        end
    end

    // registered table read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_code <= code_mem[sym_idx];
            r_rd_len  <= len_mem[sym_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
        end else if (accept && (i_in.command == CMD_LOAD) && in_range) begin
            r_loaded[sym_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_vld   <= 1'b0;
            r_st_flush <= 1'b0;
            r_st_hit   <= 1'b0;
        end else if (accept && (i_in.command == CMD_ENCODE)) begin
            r_st_vld   <= 1'b1;
            r_st_flush <= 1'b0;
            r_st_hit   <= in_range && r_loaded[sym_idx];
        end else if (accept && (i_in.command == CMD_FLUSH)) begin
            r_st_vld   <= 1'b1;
            r_st_flush <= 1'b1;
            r_st_hit   <= 1'b0;
        end else if (o_push) begin
            r_st_vld <= 1'b0;
        end
    end

    // unloaded entries read as zero length
    assign op_len = r_st_hit ? r_rd_len : '0;

    always_comb begin
        o_ctl.is_flush = r_st_flush;
        o_ctl.len      = op_len;
        // first code bit to the msb
        o_code = CODE_W'(r_rd_code) << (LEN_W'(CODE_W) - op_len);
    end

endmodule

// File: rtl/pcbp_queue.sv
// ----------------------------------------------------------------------------
// pcbp_queue - op queue
// Small FIFO decoupling table lookup from bit packing.
// ----------------------------------------------------------------------------
module pcbp_queue
    import pcbp_pkg::*;
#(
    parameter int CODE_W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_op_ctl           i_ctl,
    input  logic [CODE_W-1:0] i_code,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_vld,
    output t_op_ctl           o_ctl,
    output logic [CODE_W-1:0] o_code
);

    t_op_ctl           r_ctl  [Q_DEPTH];
    logic [CODE_W-1:0] r_code [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_AW:0]     r_cnt;
    logic [Q_AW:0]     n_cnt;

    assign o_full = r_cnt == (Q_AW+1)'(Q_DEPTH);
    assign o_vld  = r_cnt != '0;
    assign o_ctl  = r_ctl[r_rp];
    assign o_code = r_code[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wp]  <= i_ctl;
            r_code[r_wp] <= i_code;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: rtl/pcbp_back.sv
// ----------------------------------------------------------------------------
// pcbp_back - bit packer
// Shifts code bits into the pending byte, one output byte per cycle while
// the output is not stalled, and runs the flush/trailer sequence.
// ----------------------------------------------------------------------------
module pcbp_back
    import pcbp_pkg::*;
#(
    parameter int CODE_W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_vld,
    input  t_op_ctl           i_ctl,
    input  logic [CODE_W-1:0] i_code,
    output logic              o_pop,
    pcbp_out_if.source        o_out
);

    typedef enum logic [3:0] {
        ST_EMPTY = 4'b0001,
        ST_ENC   = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_TRAIL = 4'b1000
    } t_back_st;

    t_back_st          r_st;
    logic [LEN_W-1:0]  r_rem;
    logic [CODE_W-1:0] r_code;
    logic [CNT_W-1:0]  r_cnt;
    logic [6:0]        r_pend_hi;

    logic              r_ovld;
    logic [BYTE_W-1:0] r_obyte;
    logic              r_olast;

    logic [BYTE_W-1:0] pend8;
    logic [BYTE_W-1:0] top8;
    logic [3:0]        need;
    logic [3:0]        rem4;
    logic              full;
    logic              emit;
    logic              out_free;
    logic              step;
    logic              done;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_last;
    logic [BYTE_W-1:0] merged;

    // pending bits, oldest at bit r_cnt-1
    assign pend8 = {1'b0, r_pend_hi};
    assign top8  = r_code[CODE_W-1 -: BYTE_W];
    assign need  = 4'd8 - {1'b0, r_cnt};
    assign rem4  = r_rem[3:0];
    assign full  = r_rem >= LEN_W'(need);
    assign merged = (pend8 << rem4) | (top8 >> (4'd8 - rem4));

    always_comb begin
        emit      = 1'b0;
        emit_byte = '0;
        emit_last = 1'b0;
        done      = 1'b1;
        case (r_st)
            ST_EMPTY: begin
                done = 1'b1;
            end
            ST_ENC: begin
                emit      = full;
                emit_byte = (pend8 << need) | (top8 >> r_cnt);
                done      = !full || (r_rem == LEN_W'(need));
            end
            ST_FLUSH: begin
                emit = 1'b1;
                if (r_cnt != '0) begin
                    emit_byte = (pend8 << need) & BYTE_MASK;
                    done      = 1'b0;
                end else begin
                    emit_byte = '0;
                    emit_last = 1'b1;
                end
            end
            ST_TRAIL: begin
                emit      = 1'b1;
                emit_byte = BYTE_W'(r_cnt);
                emit_last = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    assign out_free = !r_ovld || o_out.ready;
    assign step     = (r_st != ST_EMPTY) && (!emit || out_free);
    assign o_pop    = i_q_vld && ((r_st == ST_EMPTY) || (step && done));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_EMPTY;
            r_cnt     <= '0;
            r_pend_hi <= '0;
        end else begin
            if (step) begin
                case (r_st)
                    ST_ENC: begin
                        if (full) begin
                            r_cnt     <= '0;
                            r_pend_hi <= '0;
                        end else begin
                            r_cnt     <= r_cnt + r_rem[CNT_W-1:0];
                            r_pend_hi <= merged[6:0];
                        end
                    end
                    ST_FLUSH: begin
                        if (r_cnt == '0) begin
                            r_pend_hi <= '0;
                        end
                    end
                    ST_TRAIL: begin
                        r_cnt     <= '0;
                        r_pend_hi <= '0;
                    end
                    default: begin
                        r_cnt <= r_cnt;
                    end
                endcase
            end
            if (o_pop) begin
                r_st <= i_ctl.is_flush ? ST_FLUSH : ST_ENC;
            end else if (step && done) begin
                r_st <= ST_EMPTY;
            end else if (step && (r_st == ST_FLUSH)) begin
                r_st <= ST_TRAIL;
            end
        end
    end

    // working code register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem  <= i_ctl.len;
            r_code <= i_code;
        end else if (step && (r_st == ST_ENC) && full) begin
            r_rem  <= r_rem - LEN_W'(need);
            r_code <= r_code << need;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (step && emit) begin
            r_ovld <= 1'b1;
        end else if (o_out.ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_obyte <= emit_byte;
            r_olast <= emit_last;
        end
    end

    assign o_out.valid    = r_ovld;
    assign o_out.out_byte = r_obyte;
    assign o_out.last     = r_olast;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - prefix code bit packer core
// Loads code table entries, encodes symbols and flushes streams through the
// word channels under random sender gaps and receiver stalls. A predictor
// tracks the table and the pending bits and yields the byte words expected.
// ----------------------------------------------------------------------------
module testbench;
    import pcbp_pkg::*;

    localparam int MAX_CODE_LEN = 64;
    localparam int SYMBOL_COUNT = 256;
    localparam int RANDOM_WORDS = 400;
    localparam int STALL_LIMIT  = 1000;   // cycles without any accepted word
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_MAX   = 10;

    // command 3 has no function in the block
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [SYM_W-1:0]     symbol;
        logic [CODE_IN_W-1:0] code_bits;
        logic [LEN_W-1:0]     code_len;
    } t_cmd_word;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_out_word;

    logic i_clk;
    logic i_rst_n;

    pcbp_in_if  in_ch ();
    pcbp_out_if out_ch ();

    prefix_code_bit_packer_core #(
        .MAX_CODE_LEN(MAX_CODE_LEN),
        .SYMBOL_COUNT(SYMBOL_COUNT)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // ------------------------------------------------------------------
    // Predictor state: shadow code table and the pending partial byte
    // ------------------------------------------------------------------
    logic [CODE_IN_W-1:0] code_mem [SYMBOL_COUNT];
    logic [LEN_W-1:0]     len_mem  [SYMBOL_COUNT];
    logic [BYTE_W-1:0]    acc_bits;
    int                   acc_cnt;
    t_out_word            expected_bytes_q[$];
    int                   loaded_syms[$];     // symbols safe to encode
    bit                   sym_loaded [SYMBOL_COUNT];

    int mismatch_count;
    int words_sent;
    int burst_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Shadow of one accepted command word
    task automatic pack_predict(input t_cmd_word w);
        logic [LEN_W-1:0] clen;
        logic [SYM_W-1:0] s;
        s = w.symbol;
        case (w.command)
            CMD_LOAD: begin
                clen = (w.code_len > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : w.code_len;
                code_mem[s] = (clen >= MAX_CODE_LEN) ? w.code_bits
                                                     : w.code_bits & ((64'd1 << clen) - 64'd1);
                len_mem[s] = clen;
            end
            CMD_ENCODE: begin
                // root bit first, shifted in at bit 0 of the accumulator
                for (int i = len_mem[s]; i > 0; i--) begin
                    acc_bits = {acc_bits[BYTE_W-2:0], code_mem[s][i-1]};
                    acc_cnt++;
                    if (acc_cnt == 8) begin
                        expected_bytes_q.push_back('{data: acc_bits, last: 1'b0});
                        acc_bits = '0;
                        acc_cnt  = 0;
                    end
                end
            end
            CMD_FLUSH: begin
                if (acc_cnt != 0)
                    expected_bytes_q.push_back('{data: acc_bits << (8 - acc_cnt), last: 1'b0});
                expected_bytes_q.push_back('{data: BYTE_W'(acc_cnt), last: 1'b1});
                acc_bits = '0;
                acc_cnt  = 0;
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    task automatic send_word(input t_cmd_word w);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.command   <= w.command;
        in_ch.symbol    <= w.symbol;
        in_ch.code_bits <= w.code_bits;
        in_ch.code_len  <= w.code_len;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pack_predict(w);
        if (w.command != CMD_UNUSED)
            words_sent++;
    endtask

    task automatic load_sym(input logic [SYM_W-1:0] s, input logic [CODE_IN_W-1:0] code,
                            input logic [LEN_W-1:0] len);
        send_word('{command: CMD_LOAD, symbol: s, code_bits: code, code_len: len});
        if (!sym_loaded[s]) begin
            sym_loaded[s] = 1'b1;
            loaded_syms.push_back(int'(s));
        end
    endtask

    task automatic encode_sym(input logic [SYM_W-1:0] s);
        send_word('{command: CMD_ENCODE, symbol: s, code_bits: {$urandom, $urandom},
                    code_len: LEN_W'($urandom)});
    endtask

    task automatic flush_stream();
        send_word('{command: CMD_FLUSH, symbol: SYM_W'($urandom),
                    code_bits: {$urandom, $urandom}, code_len: LEN_W'($urandom)});
    endtask

    // Mostly short codes, with zero, long and over-long lengths mixed in
    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return '0;
        if (r < 70) return LEN_W'($urandom_range(1, 10));
        if (r < 85) return LEN_W'($urandom_range(11, 24));
        if (r < 95) return LEN_W'($urandom_range(25, MAX_CODE_LEN));
        return LEN_W'($urandom_range(MAX_CODE_LEN + 1, 127));
    endfunction

    // ------------------------------------------------------------------
    // Receiver: stall pattern picked per stretch of cycles
    // ------------------------------------------------------------------
    initial begin
        int mode;
        int run_len;
        int low_left;
        out_ch.ready <= 1'b0;
        low_left = 0;
        forever begin
            mode    = $urandom_range(0, 3);
            run_len = $urandom_range(16, 96);
            for (int c = 0; c < run_len; c++) begin
                @(posedge i_clk);
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2: out_ch.ready <= (c % 4 == 3);
                    default: begin
                        // long stalls with short open windows
                        if (low_left == 0) begin
                            out_ch.ready <= 1'b1;
                            if ($urandom_range(0, 2) == 0)
                                low_left = $urandom_range(1, 12);
                        end else begin
                            out_ch.ready <= 1'b0;
                            low_left--;
                        end
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: every accepted byte word against the oldest expectation
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input t_out_word exp_w,
                                 input t_out_word got_w);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t: %s: expected byte %02h last %b, got byte %02h last %b",
                     $realtime, what, exp_w.data, exp_w.last, got_w.data, got_w.last);
    endtask

    always @(posedge i_clk) begin : byte_check
        t_out_word got_w;
        t_out_word exp_w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_w = '{data: out_ch.out_byte, last: out_ch.last};
            if (expected_bytes_q.size() == 0) begin
                note_mismatch("word with none expected", '0, got_w);
            end else begin
                exp_w = expected_bytes_q.pop_front();
                if (got_w.data !== exp_w.data || got_w.last !== exp_w.last)
                    note_mismatch("byte word mismatch", exp_w, got_w);
            end
        end
    end

    // Watchdog: ends the run after too long without any handshake
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[prefix_code_bit_packer_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Shortest and longest codes, clamping, dropped high bits
    task automatic test_table_extremes();
        load_sym(8'h00, 64'h1, 7'd1);
        load_sym(8'hFF, '1, 7'd64);
        load_sym(8'h80, 64'hA5A5_5A5A_F00F_0FF0, 7'd127);   // over-long, clamps to 64
        load_sym(8'h7F, '1, 7'd0);                           // no code
        load_sym(8'h55, 64'hFFFF_FFFF_FFFF_FFAA, 7'd8);      // bits above 8 dropped
        load_sym(8'h2A, 64'hF5, 7'd3);
        encode_sym(8'h00);
        encode_sym(8'hFF);
        encode_sym(8'h80);
        encode_sym(8'h7F);
        encode_sym(8'h55);
        encode_sym(8'h2A);
        encode_sym(8'h00);
        flush_stream();                                      // partial byte pending
    endtask

    // Flush with nothing pending, single-leaf stream, reload mid-stream
    task automatic test_flush_cases();
        flush_stream();
        encode_sym(8'h7F);
        encode_sym(8'h7F);
        encode_sym(8'h7F);
        flush_stream();                                      // trailer only
        encode_sym(8'h2A);
        load_sym(8'h2A, 64'h0123_4567_89AB_CDEF, 7'd65);
        encode_sym(8'h2A);
        flush_stream();
    endtask

    task automatic test_unused_command();
        send_word('{command: CMD_UNUSED, symbol: 8'hFF, code_bits: '1, code_len: 7'h7F});
        encode_sym(8'h00);
        flush_stream();
    endtask

    // Streams: loads, then encodes of loaded symbols with noise, then flush
    task automatic test_random_streams();
        int target;
        int n_load;
        int n_enc;
        int r;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            n_load = $urandom_range(1, 8);
            repeat (n_load)
                load_sym(SYM_W'($urandom), {$urandom, $urandom}, pick_len());
            n_enc = $urandom_range(4, 40);
            repeat (n_enc) begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    send_word('{command: CMD_UNUSED, symbol: SYM_W'($urandom),
                                code_bits: {$urandom, $urandom}, code_len: LEN_W'($urandom)});
                else if (r < 9)
                    load_sym(SYM_W'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]),
                             {$urandom, $urandom}, pick_len());
                else if (r < 11)
                    flush_stream();
                else
                    encode_sym(SYM_W'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]));
            end
            flush_stream();
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.command   <= CMD_LOAD;
        in_ch.symbol    <= '0;
        in_ch.code_bits <= '0;
        in_ch.code_len  <= '0;
        for (int s = 0; s < SYMBOL_COUNT; s++) begin
            code_mem[s]   = '0;
            len_mem[s]    = '0;
            sym_loaded[s] = 1'b0;
        end
        acc_bits       = '0;
        acc_cnt        = 0;
        mismatch_count = 0;
        words_sent     = 0;
        burst_left     = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_table_extremes();
        test_flush_cases();
        test_unused_command();
        test_random_streams();

        in_ch.valid <= 1'b0;
        while (expected_bytes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_bytes_q.size() == 0)
            $display("[prefix_code_bit_packer_core] OK");
        else
            $display("[prefix_code_bit_packer_core] ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/pcbp_pkg.sv
rtl/pcbp_in_if.sv
rtl/pcbp_out_if.sv
rtl/pcbp_front.sv
rtl/pcbp_queue.sv
rtl/pcbp_back.sv
rtl/prefix_code_bit_packer_core.sv
verif/testbench.sv
